>>> design/b64d_pkg.sv
// b64d_pkg: shared types and constants for the base64 decoder.
// No dependencies; used by every module of the decoder.
package b64d_pkg;

   // status codes carried on the final beat of a message
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_BADCHAR = 2'd1;
   localparam logic [1:0] STATUS_BADLEN  = 2'd2;

   localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

   // queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // one queue record: up to three result beats made by one input beat
   typedef struct packed {
      logic [2:0][7:0] bytes;      // bytes[0] goes out first
      logic [1:0]      last_idx;   // index of the last beat of the record
      logic            has_byte;   // 0: single empty end beat
      logic            final_flag; // record ends the message
      logic [1:0]      status;
   } rec_type;

endpackage

>>> design/b64d_front.sv
// b64d_front: maps characters to sextets, keeps the group state, builds queue records.
// Depends on b64d_pkg.
module b64d_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         character,
   input  logic               char_present,
   input  logic               end_of_message,
   input  logic               url_alphabet,
   output logic               push,
   output b64d_pkg::rec_type  rec
);

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } map_type;

   function automatic map_type map_char(input logic [7:0] c, input logic url);
      map_type m;
      m.ok    = 1'b1;
      m.value = 6'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         m.value = 6'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         m.value = 6'(c - 8'h61 + 8'd26);
      end else if (c >= 8'h30 && c <= 8'h39) begin
         m.value = 6'(c - 8'h30 + 8'd52);
      end else if (url && c == 8'h2D) begin
         m.value = 6'd62;
      end else if (url && c == 8'h5F) begin
         m.value = 6'd63;
      end else if (!url && c == 8'h2B) begin
         m.value = 6'd62;
      end else if (!url && c == 8'h2F) begin
         m.value = 6'd63;
      end else begin
         m.ok = 1'b0;
      end
      return m;
   endfunction

   logic [2:0][5:0] store_ff, store_in;
   logic [1:0]      pos_ff, pos_in;
   logic            pad_ff, pad_in;
   logic            bad_ff, bad_in;

   map_type    m;
   logic       take, is_pad, wr_sextet, group_done;
   logic [1:0] pos_mid;
   logic       bad_mid;

   always_comb begin
      m          = map_char(character, url_alphabet);
      take       = char_present && !pad_ff && !bad_ff;
      is_pad     = (character == b64d_pkg::PAD_CHAR);
      wr_sextet  = take && !is_pad && m.ok && (pos_ff != 2'd3);
      group_done = take && !is_pad && m.ok && (pos_ff == 2'd3);
      bad_mid    = bad_ff || (take && !is_pad && !m.ok);

      store_in = store_ff;
      if (wr_sextet) begin
         store_in[pos_ff] = m.value;
      end

      pos_mid = pos_ff;
      if (wr_sextet) begin
         pos_mid = pos_ff + 2'd1;
      end else if (group_done) begin
         pos_mid = 2'd0;
      end

      // record for the queue
      rec.bytes      = '0;
      rec.last_idx   = 2'd0;
      rec.has_byte   = 1'b0;
      rec.final_flag = end_of_message;
      rec.status     = b64d_pkg::STATUS_OK;
      if (group_done) begin
         rec.bytes[0] = {store_ff[0], store_ff[1][5:4]};
         rec.bytes[1] = {store_ff[1][3:0], store_ff[2][5:2]};
         rec.bytes[2] = {store_ff[2][1:0], m.value};
         rec.last_idx = 2'd2;
         rec.has_byte = 1'b1;
      end else if (bad_mid) begin
         rec.status = b64d_pkg::STATUS_BADCHAR;
      end else if (pos_mid == 2'd1) begin
         rec.status = b64d_pkg::STATUS_BADLEN;
      end else if (pos_mid != 2'd0) begin
         // tail of 2 or 3 sextets, using the store with this beat's sextet in it
         rec.bytes[0] = {store_in[0], store_in[1][5:4]};
         rec.bytes[1] = {store_in[1][3:0], store_in[2][5:2]};
         rec.last_idx = pos_mid - 2'd2;
         rec.has_byte = 1'b1;
      end

      push = accept && (group_done || end_of_message);

      pos_in = pos_ff;
      pad_in = pad_ff;
      bad_in = bad_ff;
      if (accept) begin
         if (end_of_message) begin
            pos_in = 2'd0;
            pad_in = 1'b0;
            bad_in = 1'b0;
         end else begin
            pos_in = pos_mid;
            pad_in = pad_ff || (take && is_pad);
            bad_in = bad_mid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         store_ff <= store_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         pad_ff <= 1'b0;
         bad_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         pad_ff <= pad_in;
         bad_ff <= bad_in;
      end
   end

endmodule

>>> design/b64d_fifo.sv
// b64d_fifo: short record queue between front and back.
// Depends on b64d_pkg.
module b64d_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64d_pkg::rec_type  push_rec,
   input  logic               pop,
   output b64d_pkg::rec_type  head,
   output logic               empty,
   output logic               full
);

   b64d_pkg::rec_type mem_ff [b64d_pkg::QDEPTH];

   logic [b64d_pkg::QPTR_W-1:0] wr_ff, wr_in;
   logic [b64d_pkg::QPTR_W-1:0] rd_ff, rd_in;
   logic [b64d_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      empty = (cnt_ff == '0);
      full  = (cnt_ff == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH));
      head  = mem_ff[rd_ff];
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

>>> design/b64d_back.sv
// b64d_back: splits queue records into result beats behind an output register.
// Depends on b64d_pkg.
module b64d_back (
   input  logic               clock,
   input  logic               reset,
   input  b64d_pkg::rec_type  head,
   input  logic               empty,
   output logic               pop,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [7:0]         out_byte,
   output logic               out_present,
   output logic [1:0]         out_status,
   output logic               out_last
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] byte_ff, byte_in;
   logic       present_ff, present_in;
   logic [1:0] status_ff, status_in;
   logic       last_ff, last_in;
   logic       load, end_of_rec;

   always_comb begin
      load       = !empty && (!valid_ff || out_ready);
      end_of_rec = (idx_ff == head.last_idx);
      pop        = load && end_of_rec;

      valid_in = valid_ff && !out_ready;
      if (load) begin
         valid_in = 1'b1;
      end

      idx_in = idx_ff;
      if (load) begin
         idx_in = end_of_rec ? 2'd0 : idx_ff + 2'd1;
      end

      byte_in    = head.has_byte ? head.bytes[idx_ff] : 8'd0;
      present_in = head.has_byte;
      last_in    = end_of_rec && head.final_flag;
      status_in  = last_in ? head.status : b64d_pkg::STATUS_OK;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff    <= byte_in;
         present_ff <= present_in;
         status_ff  <= status_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   assign out_valid   = valid_ff;
   assign out_byte    = byte_ff;
   assign out_present = present_ff;
   assign out_status  = status_ff;
   assign out_last    = last_ff;

endmodule

>>> design/base64_decoder_top.sv
// base64_decoder_top: streaming base64 decoder, standard or URL-safe alphabet.
// The front writes the queue at the accepting edge; the back then loads the output register
// from the queue head. A completed group (3 bytes) leaves the output as 3 beats.
// Throughput: 1 input beat per cycle while the queue has room; the output port moves
// 1 beat per cycle while rsp_tready is high; a 4-record queue absorbs bursts.
// Reset (synchronous, active high) clears group state, queue, output and url_alphabet.
// Depends on b64d_pkg, b64d_front, b64d_fifo, b64d_back.
module base64_decoder_top (
   input  logic        clock,
   input  logic        reset,
   // input characters
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] character
   input  logic        req_tuser,   // [0] char_present
   input  logic        req_tlast,   // end_of_message
   // decoded bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] data_byte, [9:8] status, rest zero
   output logic        rsp_tuser,   // [0] byte_present
   output logic        rsp_tlast,   // final_res
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic url_ff, url_in;
   logic csr_wr;

   b64d_pkg::rec_type rec, head;
   logic req_beat, push, pop, empty, full;
   logic [7:0] out_byte;
   logic [1:0] out_status;

   // register file: url_alphabet at byte addresses 0 to 3 (paddr[2] low); addresses 4 to 7 read zero
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      url_in = url_ff;
      if (csr_wr && !csr_paddr[2]) begin
         url_in = csr_pwdata[0];
      end
      csr_prdata = csr_paddr[2] ? 32'd0 : {31'd0, url_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         url_ff <= 1'b0;
      end else begin
         url_ff <= url_in;
      end
   end

   // front takes a beat whenever the queue has room, even if a push is not needed
   assign req_tready = !full;
   assign req_beat   = req_tvalid && req_tready;

   b64d_front u_front (
      .clock          (clock),
      .reset          (reset),
      .accept         (req_beat),
      .character      (req_tdata),
      .char_present   (req_tuser),
      .end_of_message (req_tlast),
      .url_alphabet   (url_ff),
      .push           (push),
      .rec            (rec)
   );

   b64d_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (rec),
      .pop      (pop),
      .head     (head),
      .empty    (empty),
      .full     (full)
   );

   // back turns one record into 1..3 beats, one per cycle while rsp_tready is high
   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .empty       (empty),
      .pop         (pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (out_byte),
      .out_present (rsp_tuser),
      .out_status  (out_status),
      .out_last    (rsp_tlast)
   );

   assign rsp_tdata = {6'd0, out_status, out_byte};

endmodule
